// ----- src/bpu_pkg.sv -----
package bpu_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // configuration register data width and clamped dimension width
  localparam int DIM_W  = 13;
  localparam int CCNT_W = $clog2(MAX_WIDTH);
  localparam int RCNT_W = $clog2(MAX_HEIGHT);
  localparam int IDX_W  = 24;
  localparam int IDX_FULL_W = 2 * DIM_W + 1;

  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_FORMAT = 2'd2
  } reg_idx_t;

  typedef enum logic {
    FMT_BGR24  = 1'b0,
    FMT_BGRX32 = 1'b1
  } fmt_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    fmt_t             fmt;
    logic             restart;
  } cfg_t;

  typedef struct packed {
    logic [7:0]       blue;
    logic [7:0]       green;
    logic [7:0]       red;
    logic [IDX_W-1:0] pixel_index;
    logic             last_pixel;
  } pixel_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

// ----- src/bpu_if.sv -----
interface bpu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source(output valid, output data_byte, input ready);
  modport sink(input valid, input data_byte, output ready);
endinterface

interface bpu_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [7:0]                 blue;
  logic [7:0]                 green;
  logic [7:0]                 red;
  logic [bpu_pkg::IDX_W-1:0]  pixel_index;
  logic                       last_pixel;

  modport source(output valid, output blue, output green, output red,
                 output pixel_index, output last_pixel, input ready);
  modport sink(input valid, input blue, input green, input red,
               input pixel_index, input last_pixel, output ready);
endinterface

interface bpu_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bpu_pkg::CFG_IDX_W-1:0] index;
  logic [bpu_pkg::DIM_W-1:0]     data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ----- src/bpu_cfg_regs.sv -----
module bpu_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_valid,
  output logic                          wr_ready,
  input  logic [bpu_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [bpu_pkg::DIM_W-1:0]     wr_data,
  output bpu_pkg::cfg_t                 cfg
);

  logic [bpu_pkg::DIM_W-1:0] width_r, width_nxt;
  logic [bpu_pkg::DIM_W-1:0] height_r, height_nxt;
  bpu_pkg::fmt_t             fmt_r, fmt_nxt;
  logic                      restart;

  assign wr_ready = 1'b1;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    fmt_nxt    = fmt_r;
    restart    = 1'b0;
    if (wr_valid) begin
      case (wr_index)
        bpu_pkg::REG_WIDTH: begin
          width_nxt = wr_data;
          restart   = 1'b1;
        end
        bpu_pkg::REG_HEIGHT: begin
          height_nxt = wr_data;
          restart    = 1'b1;
        end
        bpu_pkg::REG_FORMAT: begin
          fmt_nxt = bpu_pkg::fmt_t'(wr_data[0]);
          restart = 1'b1;
        end
        default: begin
          // unknown index: drop the write
          restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bpu_pkg::RESET_WIDTH;
      height_r <= bpu_pkg::RESET_HEIGHT;
      fmt_r    <= bpu_pkg::FMT_BGR24;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      fmt_r    <= fmt_nxt;
    end
  end

  assign cfg.width   = bpu_pkg::clamp_dim(width_r, bpu_pkg::DIM_W'(bpu_pkg::MAX_WIDTH));
  assign cfg.height  = bpu_pkg::clamp_dim(height_r, bpu_pkg::DIM_W'(bpu_pkg::MAX_HEIGHT));
  assign cfg.fmt     = fmt_r;
  assign cfg.restart = restart;

endmodule

// ----- src/bpu_pixel_stage.sv -----
module bpu_pixel_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  bpu_pkg::cfg_t    cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             out_free,
  output logic             emit,
  output bpu_pkg::pixel_t  pixel
);

  typedef enum logic [1:0] {
    PH_BLUE  = 2'd0,
    PH_GREEN = 2'd1,
    PH_RED   = 2'd2,
    PH_RSVD  = 2'd3
  } phase_t;

  logic                       s1_valid_r, s1_valid_nxt;
  logic [7:0]                 s1_byte_r, s1_byte_nxt;
  phase_t                     phase_r, phase_nxt;
  logic [7:0]                 blue_r, blue_nxt;
  logic [7:0]                 green_r, green_nxt;
  logic [bpu_pkg::CCNT_W-1:0] col_r, col_nxt;
  logic [bpu_pkg::RCNT_W-1:0] row_r, row_nxt;
  logic [1:0]                 pad_r, pad_nxt;

  logic                          advance;
  logic                          in_fire;
  logic                          last_col;
  logic                          last_row;
  logic [bpu_pkg::DIM_W-1:0]     rows_up;
  logic [bpu_pkg::IDX_FULL_W-1:0] idx_full;

  assign emit     = s1_valid_r && (pad_r == 2'd0) && (phase_r == PH_RED);
  assign advance  = s1_valid_r && (!emit || out_free);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  assign last_col = (bpu_pkg::DIM_W'(col_r) == cfg.width - bpu_pkg::DIM_W'(1));
  assign last_row = (bpu_pkg::DIM_W'(row_r) == cfg.height - bpu_pkg::DIM_W'(1));
  assign rows_up  = cfg.height - bpu_pkg::DIM_W'(1) - bpu_pkg::DIM_W'(row_r);
  assign idx_full = bpu_pkg::IDX_FULL_W'(rows_up) * bpu_pkg::IDX_FULL_W'(cfg.width)
                  + bpu_pkg::IDX_FULL_W'(col_r);

  assign pixel.blue        = blue_r;
  assign pixel.green       = green_r;
  assign pixel.red         = s1_byte_r;
  assign pixel.pixel_index = idx_full[bpu_pkg::IDX_W-1:0];
  assign pixel.last_pixel  = last_col && last_row;

  always_comb begin
    s1_valid_nxt = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    s1_byte_nxt  = in_fire ? in_byte : s1_byte_r;
    phase_nxt    = phase_r;
    blue_nxt     = blue_r;
    green_nxt    = green_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    pad_nxt      = pad_r;
    if (cfg.restart) begin
      phase_nxt = PH_BLUE;
      blue_nxt  = '0;
      green_nxt = '0;
      col_nxt   = '0;
      row_nxt   = '0;
      pad_nxt   = '0;
    end else if (advance) begin
      if (pad_r != 2'd0) begin
        pad_nxt = pad_r - 2'd1;
      end else begin
        case (phase_r)
          PH_BLUE: begin
            blue_nxt  = s1_byte_r;
            phase_nxt = PH_GREEN;
          end
          PH_GREEN: begin
            green_nxt = s1_byte_r;
            phase_nxt = PH_RED;
          end
          PH_RED: begin
            phase_nxt = (cfg.fmt == bpu_pkg::FMT_BGRX32) ? PH_RSVD : PH_BLUE;
            if (last_col) begin
              col_nxt = '0;
              if (cfg.fmt == bpu_pkg::FMT_BGR24) begin
                pad_nxt = cfg.width[1:0];
              end
              row_nxt = last_row ? '0 : row_r + bpu_pkg::RCNT_W'(1);
            end else begin
              col_nxt = col_r + bpu_pkg::CCNT_W'(1);
            end
          end
          default: begin
            // reserved fourth byte
            phase_nxt = PH_BLUE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      phase_r    <= PH_BLUE;
      blue_r     <= '0;
      green_r    <= '0;
      col_r      <= '0;
      row_r      <= '0;
      pad_r      <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      phase_r    <= phase_nxt;
      blue_r     <= blue_nxt;
      green_r    <= green_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      pad_r      <= pad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_byte_r <= s1_byte_nxt;
  end

  a_pad_only_24: assert property (@(posedge clk) disable iff (!rst_n)
    (pad_r != 2'd0) |-> (cfg.fmt == bpu_pkg::FMT_BGR24))
    else $error("row padding pending in 32-bit mode");

  a_rsvd_only_32: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_RSVD) |-> (cfg.fmt == bpu_pkg::FMT_BGRX32))
    else $error("reserved byte phase in 24-bit mode");

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    bpu_pkg::DIM_W'(col_r) < cfg.width)
    else $error("column counter beyond image width");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !out_free && !cfg.restart) |=>
      ($stable(col_r) && $stable(row_r) && s1_valid_r && $stable(s1_byte_r)))
    else $error("pixel state moved while its result was stalled");

endmodule

// ----- src/bpu_out_reg.sv -----
module bpu_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  bpu_pkg::pixel_t pixel_in,
  output logic            out_free,
  output logic            out_valid,
  input  logic            out_ready,
  output bpu_pkg::pixel_t pixel_out
);

  logic            valid_r, valid_nxt;
  bpu_pkg::pixel_t pixel_r, pixel_nxt;
  logic            take;

  assign out_free = !valid_r || out_ready;
  assign take     = load && out_free;

  always_comb begin
    valid_nxt = take ? 1'b1 : (out_ready ? 1'b0 : valid_r);
    pixel_nxt = take ? pixel_in : pixel_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pixel_r <= pixel_nxt;
  end

  assign out_valid = valid_r;
  assign pixel_out = pixel_r;

endmodule

// ----- src/bmp_pixel_unpacker.sv -----
// BMP pixel unpacker: turns the byte stream of a BMP pixel array into
// frame-buffer pixels (blue, green, red, top-down index, last flag).
//
// Channels: in_bus carries one data byte per transaction, out_bus one
// pixel per transaction, cfg_bus writes width (index 0), height (index 1)
// and format (index 2, 0 = 24-bit BGR with row padding, 1 = 32-bit BGRX).
// A write to any of these registers restarts the image; drop a write to an
// unknown index. Write only while idle. cfg_bus is always ready.
//
// Throughput: one byte per clock, with no bubbles, while out_bus takes
// its pixels. A pixel costs three bytes (four in 32-bit mode) plus the
// row padding bytes. Path: the red byte of a pixel is registered in the
// input stage, and the pixel it completes in the output register that
// drives out_bus. Between the registers lies one 13x13 index multiply
// and add, (height-1-row)*width + col.
// Reset: width 640, height 480, 24-bit format, counters at image start.
// Stall: while out_bus holds a pixel that is not taken, the output
// register holds it; one further byte may wait in the input stage, and
// in_bus.ready drops only when that byte would complete another pixel.
module bmp_pixel_unpacker (
  input  logic         clk,
  input  logic         rst_n,
  bpu_byte_if.sink     in_bus,
  bpu_pixel_if.source  out_bus,
  bpu_cfg_if.sink      cfg_bus
);

  bpu_pkg::cfg_t   cfg;
  bpu_pkg::pixel_t stage_pixel;
  bpu_pkg::pixel_t out_pixel;
  logic            stage_emit;
  logic            out_free;

  // register file; clamps width and height to their legal range
  bpu_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_bus.valid),
    .wr_ready (cfg_bus.ready),
    .wr_index (cfg_bus.index),
    .wr_data  (cfg_bus.data),
    .cfg      (cfg)
  );

  // input register plus phase, counter and padding state; advance the
  // state only when the staged byte leaves
  bpu_pixel_stage u_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .in_byte  (in_bus.data_byte),
    .out_free (out_free),
    .emit     (stage_emit),
    .pixel    (stage_pixel)
  );

  // result register; hold the pixel until the receiver takes it
  bpu_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (stage_emit),
    .pixel_in  (stage_pixel),
    .out_free  (out_free),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .pixel_out (out_pixel)
  );

  assign out_bus.blue        = out_pixel.blue;
  assign out_bus.green       = out_pixel.green;
  assign out_bus.red         = out_pixel.red;
  assign out_bus.pixel_index = out_pixel.pixel_index;
  assign out_bus.last_pixel  = out_pixel.last_pixel;

endmodule

// ----- tb/tb_bmp_pixel_unpacker.sv -----
module tb_bmp_pixel_unpacker;
  timeunit 1ns;
  timeprecision 1ps;

  // Index with no register behind it; the block must ignore a write to it.
  localparam logic [bpu_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Cycles to let pass after the last expected pixel before touching the
  // registers: a trailing padding or reserved byte has to leave the input
  // stage; the rest is margin.
  localparam int PIPE_DRAIN = 4;
  localparam int END_DRAIN = 10;

  // Longest stretch without any transaction on any channel before the run
  // is declared hung. The worst legal stretch is the sink hold-off.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int MAX_REPORTS = 200;

  // Byte position inside the pixel being assembled.
  typedef enum logic [1:0] {
    PH_BLUE,
    PH_GREEN,
    PH_RED,
    PH_RESERVED
  } byte_phase_t;

  logic clk = 1'b0;
  logic rst_n;

  bpu_byte_if  byte_if ();
  bpu_pixel_if pixel_if ();
  bpu_cfg_if   cfg_if ();

  bmp_pixel_unpacker i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (byte_if),
    .out_bus (pixel_if),
    .cfg_bus (cfg_if)
  );

  always #10 clk = ~clk;

  // Knobs shared by the stimulus tasks and the pixel sink.
  bit gaps_on;
  bit sink_stalls_on;
  int hold_req;
  int mismatch_count;

  // Pixels the block still owes us, oldest first.
  bpu_pkg::pixel_t expected_pixels[$];

  // Shadow of the block: registers and unpacking state.
  logic [bpu_pkg::DIM_W-1:0] width_reg;
  logic [bpu_pkg::DIM_W-1:0] height_reg;
  bpu_pkg::fmt_t             fmt_reg;
  byte_phase_t               phase;
  logic [7:0]                held_b;
  logic [7:0]                held_g;
  int unsigned               col_pos;
  int unsigned               row_pos;
  logic [1:0]                pad_left;

  // Zero acts as one, anything above the maximum acts as the maximum.
  function automatic int unsigned eff_dim(input int unsigned v, input int unsigned maxv);
    if (v == 0) begin
      return 1;
    end
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic void restart_image();
    phase    = PH_BLUE;
    held_b   = '0;
    held_g   = '0;
    col_pos  = 0;
    row_pos  = 0;
    pad_left = '0;
  endfunction

  // Mirror one register write; any known index also restarts the image.
  function automatic void apply_write(input logic [bpu_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [bpu_pkg::DIM_W-1:0] value);
    case (idx)
      bpu_pkg::REG_WIDTH:  width_reg = value;
      bpu_pkg::REG_HEIGHT: height_reg = value;
      bpu_pkg::REG_FORMAT: fmt_reg = bpu_pkg::fmt_t'(value[0]);
      default:             return;
    endcase
    restart_image();
  endfunction

  // Advance the shadow by one pixel-array byte and queue the pixel it
  // completes, if any.
  function automatic void unpack_byte(input logic [7:0] b);
    int unsigned     w;
    int unsigned     h;
    logic            last_col;
    logic            last_row;
    bpu_pkg::pixel_t px;
    w = eff_dim(width_reg, bpu_pkg::MAX_WIDTH);
    h = eff_dim(height_reg, bpu_pkg::MAX_HEIGHT);
    // Drop row padding first; it never touches the pixel phase.
    if (pad_left != 0) begin
      pad_left--;
      return;
    end
    case (phase)
      PH_BLUE: begin
        held_b = b;
        phase  = PH_GREEN;
      end
      PH_GREEN: begin
        held_g = b;
        phase  = PH_RED;
      end
      PH_RESERVED: phase = PH_BLUE;
      default: begin
        if (col_pos >= w) col_pos = w - 1;
        if (row_pos >= h) row_pos = h - 1;
        last_col = (col_pos == w - 1);
        last_row = (row_pos == h - 1);
        // Rows arrive bottom-up; flip them into top-down buffer order.
        px.blue        = held_b;
        px.green       = held_g;
        px.red         = b;
        px.pixel_index = bpu_pkg::IDX_W'((h - 1 - row_pos) * w + col_pos);
        px.last_pixel  = last_col && last_row;
        expected_pixels.push_back(px);
        phase = (fmt_reg == bpu_pkg::FMT_BGRX32) ? PH_RESERVED : PH_BLUE;
        if (last_col) begin
          col_pos = 0;
          if (fmt_reg == bpu_pkg::FMT_BGR24) pad_left = 2'(w & 3);
          row_pos = last_row ? 0 : row_pos + 1;
        end else begin
          col_pos++;
        end
      end
    endcase
  endfunction

  // Bytes in one whole image, padding included.
  function automatic int image_bytes(input int w, input int h, input logic fmt);
    int ew;
    int eh;
    ew = eff_dim(w, bpu_pkg::MAX_WIDTH);
    eh = eff_dim(h, bpu_pkg::MAX_HEIGHT);
    return fmt ? eh * 4 * ew : eh * (3 * ew + (ew & 3));
  endfunction

  // Idle length: mostly short, now and then a long stretch.
  function automatic int idle_len();
    return ($urandom_range(99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatch_count++;
    // Keep the log bounded if the block goes badly wrong.
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
    end
  endfunction

  // Sample all three channels at the clock edge. Every input is driven with
  // nonblocking assignments, so the values seen here are the pre-edge ones.
  always @(posedge clk) begin
    bpu_pkg::pixel_t want;
    if (rst_n === 1'b1) begin
      if (pixel_if.valid === 1'b1 && pixel_if.ready === 1'b1) begin
        if (expected_pixels.size() == 0) begin
          mismatch_count++;
          $display("%0t: pixel with no expectation, expected none, actual index 0x%0h",
                   $time, pixel_if.pixel_index);
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_if.blue !== want.blue)
            flag_mismatch("blue", want.blue, pixel_if.blue);
          if (pixel_if.green !== want.green)
            flag_mismatch("green", want.green, pixel_if.green);
          if (pixel_if.red !== want.red)
            flag_mismatch("red", want.red, pixel_if.red);
          if (pixel_if.pixel_index !== want.pixel_index)
            flag_mismatch("pixel_index", want.pixel_index, pixel_if.pixel_index);
          if (pixel_if.last_pixel !== want.last_pixel)
            flag_mismatch("last_pixel", want.last_pixel, pixel_if.last_pixel);
        end
      end
      if (byte_if.valid === 1'b1 && byte_if.ready === 1'b1) begin
        unpack_byte(byte_if.data_byte);
      end
      if (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1) begin
        apply_write(cfg_if.index, cfg_if.data);
      end
    end
  end

  // Pixel sink: random stalls, plus a long hold-off whenever a test asks
  // for one through hold_req.
  initial begin
    int stall_left;
    pixel_if.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        pixel_if.ready <= 1'b0;
        hold_req--;
      end else if (stall_left > 0) begin
        pixel_if.ready <= 1'b0;
        stall_left--;
      end else if (sink_stalls_on && $urandom_range(3) == 0) begin
        pixel_if.ready <= 1'b0;
        stall_left = idle_len() - 1;
      end else begin
        pixel_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no transaction happens on any channel for
  // too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((byte_if.valid === 1'b1 && byte_if.ready === 1'b1) ||
          (pixel_if.valid === 1'b1 && pixel_if.ready === 1'b1) ||
          (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Offer one byte, after an optional gap, and hold it until the block
  // takes it. Leave valid high on return so back-to-back bytes need no
  // second assignment in the same step.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (gaps_on && $urandom_range(2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    do @(posedge clk); while (byte_if.ready !== 1'b1);
  endtask

  // Drop valid, wait for every owed pixel, then let trailing padding or a
  // reserved byte clear the pipeline.
  task automatic settle();
    byte_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bpu_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bpu_pkg::DIM_W-1:0] value);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
  endtask

  // Reset values: 640x480, 24-bit. First pixel lands at the start of the
  // bottom buffer row.
  task automatic test_default_config();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
  endtask

  // One-pixel rows: the first row is followed by its one padding byte, and
  // the second row closes the image.
  task automatic test_padding_and_last();
    write_reg(bpu_pkg::REG_WIDTH, bpu_pkg::DIM_W'(1));
    write_reg(bpu_pkg::REG_HEIGHT, bpu_pkg::DIM_W'(2));
    write_reg(bpu_pkg::REG_FORMAT, bpu_pkg::DIM_W'(bpu_pkg::FMT_BGR24));
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_byte(8'h01);
    send_byte(8'h7F);
    send_byte(8'hFE);
  endtask

  // Width zero acts as one, an oversized height clamps to the maximum, and
  // format data with every bit set selects 32-bit with the fourth byte dropped.
  task automatic test_clamp_and_bgrx();
    write_reg(bpu_pkg::REG_WIDTH, bpu_pkg::DIM_W'(0));
    write_reg(bpu_pkg::REG_HEIGHT, {bpu_pkg::DIM_W{1'b1}});
    write_reg(bpu_pkg::REG_FORMAT, {bpu_pkg::DIM_W{1'b1}});
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    send_byte(8'hFF);
    send_byte(8'h44);
    send_byte(8'h55);
    send_byte(8'h66);
    send_byte(8'h00);
  endtask

  // A write to the unused index must leave a half-built pixel alone; a real
  // write mid-image must throw it away and start over.
  task automatic test_restart_on_write();
    write_reg(bpu_pkg::REG_WIDTH, bpu_pkg::DIM_W'(3));
    write_reg(bpu_pkg::REG_HEIGHT, bpu_pkg::DIM_W'(2));
    write_reg(bpu_pkg::REG_FORMAT, {{(bpu_pkg::DIM_W - 1){1'b1}}, bpu_pkg::FMT_BGR24});
    send_byte(8'h10);
    send_byte(8'h20);
    send_byte(8'h30);
    send_byte(8'h40);
    write_reg(REG_UNUSED, {bpu_pkg::DIM_W{1'b1}});
    send_byte(8'h50);
    send_byte(8'h60);
    send_byte(8'h70);
    write_reg(bpu_pkg::REG_HEIGHT, bpu_pkg::DIM_W'(2));
    send_byte(8'h80);
    send_byte(8'h90);
    send_byte(8'hA0);
  endtask

  // Hold the sink off for a long stretch while bytes keep coming at full
  // rate, so the block backs up and has to drop its input ready.
  task automatic test_stall_fill();
    write_reg(bpu_pkg::REG_WIDTH, bpu_pkg::DIM_W'(5));
    write_reg(bpu_pkg::REG_HEIGHT, bpu_pkg::DIM_W'(3));
    write_reg(bpu_pkg::REG_FORMAT, bpu_pkg::DIM_W'(bpu_pkg::FMT_BGR24));
    gaps_on  = 1'b0;
    hold_req = HOLD_OFF_CYCLES;
    repeat (60) send_byte(8'($urandom_range(255)));
    gaps_on = 1'b1;
  endtask

  // Random images. Start with the extreme settings, then mostly small
  // images sent whole (often twice, to see the wrap), some cut short by the
  // next reconfiguration, and a few huge ones that only get a short burst.
  task automatic test_random_images();
    int   w;
    int   h;
    int   full;
    int   nbytes;
    int   sent;
    int   r;
    logic fmt;
    sent = 0;
    for (int k = 0; sent < 1300; k++) begin
      gaps_on        = ($urandom_range(3) != 0);
      sink_stalls_on = ($urandom_range(3) != 0);
      case (k)
        0: begin w = bpu_pkg::MAX_WIDTH; h = bpu_pkg::MAX_HEIGHT; fmt = bpu_pkg::FMT_BGRX32; end
        1: begin w = 8191; h = 8191; fmt = bpu_pkg::FMT_BGR24; end
        2: begin w = 1; h = 1; fmt = bpu_pkg::FMT_BGRX32; end
        3: begin w = 0; h = 0; fmt = bpu_pkg::FMT_BGR24; end
        default: begin
          r   = $urandom_range(19);
          fmt = 1'($urandom_range(1));
          if (r == 0) begin
            w = $urandom_range(bpu_pkg::MAX_WIDTH + 1, 8191);
            h = $urandom_range(1, 8191);
          end else if (r == 1) begin
            w = $urandom_range(1000, bpu_pkg::MAX_WIDTH);
            h = $urandom_range(1, bpu_pkg::MAX_HEIGHT);
          end else begin
            w = $urandom_range(1, 9);
            h = $urandom_range(1, 4);
          end
        end
      endcase
      if ($urandom_range(7) == 0) write_reg(REG_UNUSED, bpu_pkg::DIM_W'($urandom_range(8191)));
      write_reg(bpu_pkg::REG_WIDTH, bpu_pkg::DIM_W'(w));
      write_reg(bpu_pkg::REG_HEIGHT, bpu_pkg::DIM_W'(h));
      write_reg(bpu_pkg::REG_FORMAT, {12'($urandom_range(4095)), fmt});
      full = image_bytes(w, h, fmt);
      if (full > 60) begin
        nbytes = $urandom_range(10, 40);
      end else if ($urandom_range(4) == 0) begin
        nbytes = $urandom_range(1, full);
      end else begin
        nbytes = full * $urandom_range(1, 2);
      end
      repeat (nbytes) send_byte(8'($urandom_range(255)));
      sent += nbytes;
    end
  endtask

  initial begin
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = bpu_pkg::REG_WIDTH;
    cfg_if.data       = '0;
    rst_n             = 1'b0;
    gaps_on           = 1'b1;
    sink_stalls_on    = 1'b1;
    hold_req          = 0;
    mismatch_count    = 0;
    width_reg         = bpu_pkg::RESET_WIDTH;
    height_reg        = bpu_pkg::RESET_HEIGHT;
    fmt_reg           = bpu_pkg::FMT_BGR24;
    restart_image();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_config();
    test_padding_and_last();
    test_clamp_and_bgrx();
    test_restart_on_write();
    test_stall_fill();
    test_random_images();

    // Drain what is still owed, then watch a little longer for strays.
    settle();
    repeat (END_DRAIN) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/bpu_pkg.sv
src/bpu_if.sv
src/bpu_cfg_regs.sv
src/bpu_pixel_stage.sv
src/bpu_out_reg.sv
src/bmp_pixel_unpacker.sv
tb/tb_bmp_pixel_unpacker.sv
